### rtl/core/tcbi_pkg.sv
package tcbi_pkg;

  localparam int MAX_SITES = 4096;
  localparam int SITE_W    = 12;
  localparam int CNT_W     = 13;
  localparam int NUM_CTX   = 8;
  localparam int CTX_W     = 3;

  // operation codes
  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_BUILD    = 3'd1;
  localparam logic [2:0] OP_MUT_POS  = 3'd2;
  localparam logic [2:0] OP_MUT_RANK = 3'd3;
  localparam logic [2:0] OP_COUNT    = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_BAD_CTX   = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  // site-to-slot read address select
  typedef enum logic [1:0] {
    TSEL_SITE   = 2'd0,
    TSEL_SITEP1 = 2'd1,
    TSEL_TARGET = 2'd2,
    TSEL_SWAP   = 2'd3
  } tsel_t;

  typedef struct packed {
    logic        accept;
    logic        lb_wr;
    logic        b_start;
    logic        b_run;
    logic        s_rank;
    tsel_t       tsel;
    logic [1:0]  mv;
    logic        site_rank;
    logic        mpos_we;
    logic        ctx_cap_cl;
    logic        ctx_cap_r;
    logic        loc_cap;
    logic        sw_b;
    logic        sw_c;
    logic        sw_d;
    logic        res_clr;
    logic        res_status_we;
    logic [1:0]  res_status;
    logic        res_cnt_we;
    logic        res_bit_edge_we;
    logic        res_bit_ctx_we;
    logic        out_load;
  } cmd_t;

  typedef struct packed {
    logic built;
    logic ld_bad;
    logic mut_bad;
    logic rank_bad;
    logic rd_edge;
    logic b_done;
    logic sw_last;
    logic left_in;
    logic right_in;
  } sts_t;

endpackage

### rtl/core/tcbi_dp.sv
module tcbi_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_wdata,
  input  logic [11:0]          in_position,
  input  logic                 in_bit_value,
  input  logic [2:0]           in_context_code,
  input  logic [11:0]          in_rank,
  input  tcbi_pkg::cmd_t       cmd,
  output tcbi_pkg::sts_t       sts,
  output logic [1:0]           out_status,
  output logic [11:0]          out_mutated_position,
  output logic [11:0]          out_count,
  output logic                 out_site_bit
);

  // slot/site maps and loaded bits
  logic [11:0] s2s_mem [tcbi_pkg::MAX_SITES];
  logic [11:0] t2s_mem [tcbi_pkg::MAX_SITES];
  logic        lb_mem  [tcbi_pkg::MAX_SITES];

  logic [12:0] sc_r;
  logic        built_r, fbit_r, lbit_r;
  logic [tcbi_pkg::NUM_CTX-1:0][11:0] bend_r;

  logic [11:0] pos_r, rank_r, site_r, loc_r, sa_r, sb_r, ta_r;
  logic        bit_r;
  logic [2:0]  qctx_r, c_r, cl_r, cr_r, cur_r, to_r;
  logic        dn_r, sw1_r;

  logic [12:0] bj_r;
  logic [11:0] bk_r, slot_r;
  logic        bv_r;
  logic [2:0]  bc_r;
  logic [1:0]  win_r;

  logic [1:0]  res_status_r;
  logic [11:0] res_mpos_r, res_cnt_r;
  logic        res_bit_r;
  logic [1:0]  ost_r;
  logic [11:0] ompos_r, ocnt_r;
  logic        obit_r;

  logic [11:0] s_rd0, s_rd1, t_rd0, t_rd1;
  logic        lb_rd;

  logic [12:0] n_w, pos13, freq_w;
  logic [11:0] qstart_w, rank_slot_w, tgt_w, swa_w, swb_w;
  logic [11:0] s_ra0, s_ra1, t_ra0, t_ra1;
  logic        s_we, t_we;
  logic [11:0] s_wa, s_wd, t_wa, t_wd;
  logic        bhit_w, pass_end_w;
  logic [2:0]  from_w;
  logic [2:0]  to_w;
  logic [2:0]  ctx0_w, ctx1_w;

  function automatic logic [2:0] ctx_of(input logic [11:0] idx,
                                        input logic [7:0][11:0] e);
    logic [2:0] res;
    res = 3'd7;
    for (int c = 6; c >= 0; c--) begin
      if (e[c] >= idx) res = 3'(c);
    end
    return res;
  endfunction

  function automatic logic [11:0] bstart(input logic [2:0] c,
                                         input logic [7:0][11:0] e);
    return (c == 3'd0) ? 12'd1 : e[c - 3'd1] + 12'd1;
  endfunction

  // clamp site count to the legal range
  always_comb begin
    if (sc_r < 13'd3) n_w = 13'd3;
    else if (sc_r > 13'(tcbi_pkg::MAX_SITES)) n_w = 13'(tcbi_pkg::MAX_SITES);
    else n_w = sc_r;
  end

  // bucket of the slots just read from the site-to-slot map
  assign ctx0_w = ctx_of(t_rd0, bend_r);
  assign ctx1_w = ctx_of(t_rd1, bend_r);

  assign pos13       = {1'b0, pos_r};
  assign qstart_w    = bstart(qctx_r, bend_r);
  assign freq_w      = {1'b0, bend_r[qctx_r]} + 13'd1 - {1'b0, qstart_w};
  assign rank_slot_w = qstart_w - 12'd1 + rank_r;

  assign sts.built    = built_r;
  assign sts.ld_bad   = pos13 >= n_w;
  assign sts.mut_bad  = (pos_r == 12'd0) || (pos13 > n_w - 13'd2);
  assign sts.rank_bad = (freq_w == 13'd0) || (rank_r == 12'd0) || ({1'b0, rank_r} > freq_w);
  assign sts.rd_edge  = (pos_r == 12'd0) || (pos13 == n_w - 13'd1);
  assign sts.left_in  = site_r > 12'd1;
  assign sts.right_in = ({1'b0, site_r} + 13'd2) < n_w;
  assign sts.sw_last  = !sw1_r && (dn_r ? (cur_r - 3'd1 == to_r) : (cur_r + 3'd1 == to_r));

  // build pass: window of three bits around site bk_r-1
  assign bhit_w     = cmd.b_run && bv_r && (bk_r >= 12'd2) && ({win_r, lb_rd} == bc_r);
  assign pass_end_w = cmd.b_run && bv_r && ({1'b0, bk_r} == n_w - 13'd1);
  assign sts.b_done = pass_end_w && (bc_r == 3'd7);

  // move target and bucket pair
  always_comb begin
    case (cmd.mv)
      2'd1:    begin tgt_w = site_r - 12'd1; from_w = cl_r; to_w = cl_r ^ 3'd1; end
      2'd2:    begin tgt_w = site_r + 12'd1; from_w = cr_r; to_w = cr_r ^ 3'd4; end
      default: begin tgt_w = site_r;         from_w = c_r;  to_w = c_r ^ 3'd2;  end
    endcase
  end

  // swap slot pair
  always_comb begin
    if (sw1_r) begin
      swa_w = dn_r ? bstart(cur_r, bend_r) : bend_r[cur_r];
      swb_w = loc_r;
    end else if (dn_r) begin
      swa_w = bend_r[cur_r - 3'd1] + 12'd1;
      swb_w = bstart(cur_r - 3'd1, bend_r);
    end else begin
      swa_w = bend_r[cur_r];
      swb_w = bend_r[cur_r + 3'd1];
    end
  end

  assign s_ra0 = cmd.s_rank ? rank_slot_w : swa_w;
  assign s_ra1 = swb_w;

  always_comb begin
    case (cmd.tsel)
      tcbi_pkg::TSEL_SITEP1: t_ra0 = site_r + 12'd1;
      tcbi_pkg::TSEL_TARGET: t_ra0 = tgt_w;
      tcbi_pkg::TSEL_SWAP:   t_ra0 = s_rd0;
      default:               t_ra0 = site_r;
    endcase
  end
  assign t_ra1 = (cmd.tsel == tcbi_pkg::TSEL_SWAP) ? s_rd1 : site_r - 12'd1;

  // write port muxes
  always_comb begin
    s_we = 1'b0; s_wa = swa_w; s_wd = sb_r;
    t_we = 1'b0; t_wa = sa_r;  t_wd = t_rd1;
    if (bhit_w) begin
      s_we = 1'b1; s_wa = slot_r;        s_wd = bk_r - 12'd1;
      t_we = 1'b1; t_wa = bk_r - 12'd1;  t_wd = slot_r;
    end else if (cmd.sw_c) begin
      s_we = 1'b1; s_wa = swa_w; s_wd = sb_r;
      t_we = 1'b1; t_wa = sa_r;  t_wd = t_rd1;
    end else if (cmd.sw_d) begin
      s_we = 1'b1; s_wa = swb_w; s_wd = sa_r;
      t_we = 1'b1; t_wa = sb_r;  t_wd = ta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) s2s_mem[s_wa] <= s_wd;
    s_rd0 <= s2s_mem[s_ra0];
    s_rd1 <= s2s_mem[s_ra1];
  end

  always_ff @(posedge clk) begin
    if (t_we) t2s_mem[t_wa] <= t_wd;
    t_rd0 <= t2s_mem[t_ra0];
    t_rd1 <= t2s_mem[t_ra1];
  end

  always_ff @(posedge clk) begin
    if (cmd.lb_wr) lb_mem[pos_r] <= bit_r;
    lb_rd <= lb_mem[bj_r[11:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r    <= 13'(tcbi_pkg::MAX_SITES);
      built_r <= 1'b0;
      fbit_r  <= 1'b0;
      lbit_r  <= 1'b0;
      bend_r  <= '0;
      bv_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        sc_r    <= cfg_wdata;
        built_r <= 1'b0;
      end
      if (cmd.b_start) begin
        bv_r <= 1'b0;
      end else if (cmd.b_run) begin
        bv_r <= bj_r < n_w;
        if (bv_r && bk_r == 12'd0) fbit_r <= lb_rd;
        if (pass_end_w) begin
          lbit_r       <= lb_rd;
          bend_r[bc_r] <= bhit_w ? slot_r : slot_r - 12'd1;
        end
        if (sts.b_done) built_r <= 1'b1;
      end
      if (cmd.sw_d && !sw1_r) begin
        if (dn_r) bend_r[cur_r - 3'd1] <= bend_r[cur_r - 3'd1] + 12'd1;
        else      bend_r[cur_r]        <= bend_r[cur_r] - 12'd1;
      end
    end
  end

  // build counters
  always_ff @(posedge clk) begin
    if (cmd.b_start) begin
      bj_r   <= '0;
      bc_r   <= '0;
      slot_r <= 12'd1;
    end else if (cmd.b_run) begin
      bk_r <= bj_r[11:0];
      if (bj_r < n_w) bj_r <= bj_r + 13'd1;
      if (bv_r) win_r <= {win_r[0], lb_rd};
      if (bhit_w) slot_r <= slot_r + 12'd1;
      if (pass_end_w) begin
        bj_r <= '0;
        bc_r <= bc_r + 3'd1;
      end
    end
  end

  // item payload, context and swap registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_r  <= in_position;
      bit_r  <= in_bit_value;
      qctx_r <= in_context_code;
      rank_r <= in_rank;
      site_r <= in_position;
    end
    if (cmd.site_rank) site_r <= s_rd0;
    if (cmd.ctx_cap_cl) begin
      c_r  <= ctx0_w;
      cl_r <= ctx1_w;
    end
    if (cmd.ctx_cap_r) cr_r <= ctx0_w;
    if (cmd.loc_cap) begin
      loc_r <= t_rd0;
      cur_r <= from_w;
      to_r  <= to_w;
      dn_r  <= to_w < from_w;
      sw1_r <= 1'b1;
    end
    if (cmd.sw_b) begin
      sa_r <= s_rd0;
      sb_r <= s_rd1;
    end
    if (cmd.sw_c) ta_r <= t_rd0;
    if (cmd.sw_d) begin
      sw1_r <= 1'b0;
      if (!sw1_r) cur_r <= dn_r ? cur_r - 3'd1 : cur_r + 3'd1;
    end
  end

  // result and output registers
  always_ff @(posedge clk) begin
    if (cmd.res_clr) begin
      res_status_r <= tcbi_pkg::ST_OK;
      res_mpos_r   <= '0;
      res_cnt_r    <= '0;
      res_bit_r    <= 1'b0;
    end
    if (cmd.res_status_we)   res_status_r <= cmd.res_status;
    if (cmd.mpos_we)         res_mpos_r   <= site_r;
    if (cmd.res_cnt_we)      res_cnt_r    <= freq_w[11:0];
    if (cmd.res_bit_edge_we) res_bit_r    <= (pos_r == 12'd0) ? fbit_r : lbit_r;
    if (cmd.res_bit_ctx_we)  res_bit_r    <= ctx0_w[1];
    if (cmd.out_load) begin
      ost_r   <= res_status_r;
      ompos_r <= res_mpos_r;
      ocnt_r  <= res_cnt_r;
      obit_r  <= res_bit_r;
    end
  end

  assign out_status           = ost_r;
  assign out_mutated_position = ompos_r;
  assign out_count            = ocnt_r;
  assign out_site_bit         = obit_r;

endmodule

### rtl/core/tcbi_ctrl.sv
module tcbi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_op,
  output logic             out_valid,
  input  logic             out_stall,
  input  tcbi_pkg::sts_t   sts,
  output tcbi_pkg::cmd_t   cmd
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DEC    = 15'b000000000000010,
    S_BLD    = 15'b000000000000100,
    S_RK     = 15'b000000000001000,
    S_RB     = 15'b000000000010000,
    S_CT0    = 15'b000000000100000,
    S_CT1    = 15'b000000001000000,
    S_CT2    = 15'b000000010000000,
    S_MV_LOC = 15'b000000100000000,
    S_MV_CAP = 15'b000001000000000,
    S_SW_A   = 15'b000010000000000,
    S_SW_B   = 15'b000100000000000,
    S_SW_C   = 15'b001000000000000,
    S_SW_D   = 15'b010000000000000,
    S_FIN    = 15'b100000000000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  op_r;
  logic [1:0]  mv_r, mv_nxt;
  logic        out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    mv_nxt        = mv_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.tsel      = tcbi_pkg::TSEL_SITE;
    cmd.mv        = mv_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.res_clr = 1'b1;
        state_nxt   = S_FIN;
        case (op_r)
          tcbi_pkg::OP_LOAD: begin
            if (sts.ld_bad) begin
              cmd.res_status_we = 1'b1;
              cmd.res_status    = tcbi_pkg::ST_BAD_POS;
            end else begin
              cmd.lb_wr = 1'b1;
            end
          end
          tcbi_pkg::OP_BUILD: begin
            cmd.b_start = 1'b1;
            state_nxt   = S_BLD;
          end
          tcbi_pkg::OP_MUT_POS, tcbi_pkg::OP_MUT_RANK,
          tcbi_pkg::OP_COUNT, tcbi_pkg::OP_READ: begin
            cmd.res_status_we = 1'b1;
            if (!sts.built) begin
              cmd.res_status = tcbi_pkg::ST_NOT_BUILT;
            end else if (op_r == tcbi_pkg::OP_MUT_POS) begin
              if (sts.mut_bad) cmd.res_status = tcbi_pkg::ST_BAD_POS;
              else state_nxt = S_CT0;
            end else if (op_r == tcbi_pkg::OP_MUT_RANK) begin
              if (sts.rank_bad) begin
                cmd.res_status = tcbi_pkg::ST_BAD_CTX;
              end else begin
                cmd.s_rank = 1'b1;
                state_nxt  = S_RK;
              end
            end else if (op_r == tcbi_pkg::OP_COUNT) begin
              cmd.res_cnt_we = 1'b1;
            end else begin
              if (sts.ld_bad) cmd.res_status = tcbi_pkg::ST_BAD_POS;
              else if (sts.rd_edge) cmd.res_bit_edge_we = 1'b1;
              else state_nxt = S_RB;
            end
          end
          default: ;
        endcase
      end
      S_BLD: begin
        cmd.b_run = 1'b1;
        if (sts.b_done) state_nxt = S_FIN;
      end
      S_RK: begin
        cmd.site_rank = 1'b1;
        state_nxt     = S_CT0;
      end
      S_RB: begin
        cmd.res_bit_ctx_we = 1'b1;
        state_nxt          = S_FIN;
      end
      S_CT0: begin
        cmd.mpos_we = 1'b1;
        state_nxt   = S_CT1;
      end
      S_CT1: begin
        cmd.ctx_cap_cl = 1'b1;
        cmd.tsel       = tcbi_pkg::TSEL_SITEP1;
        state_nxt      = S_CT2;
      end
      S_CT2: begin
        cmd.ctx_cap_r = 1'b1;
        mv_nxt        = 2'd0;
        state_nxt     = S_MV_LOC;
      end
      S_MV_LOC: begin
        cmd.tsel  = tcbi_pkg::TSEL_TARGET;
        state_nxt = S_MV_CAP;
      end
      S_MV_CAP: begin
        cmd.loc_cap = 1'b1;
        state_nxt   = S_SW_A;
      end
      S_SW_A: state_nxt = S_SW_B;
      S_SW_B: begin
        cmd.sw_b  = 1'b1;
        cmd.tsel  = tcbi_pkg::TSEL_SWAP;
        state_nxt = S_SW_C;
      end
      S_SW_C: begin
        cmd.sw_c  = 1'b1;
        state_nxt = S_SW_D;
      end
      S_SW_D: begin
        cmd.sw_d = 1'b1;
        if (!sts.sw_last) begin
          state_nxt = S_SW_A;
        end else if (mv_r == 2'd0 && sts.left_in) begin
          mv_nxt    = 2'd1;
          state_nxt = S_MV_LOC;
        end else if (mv_r != 2'd2 && sts.right_in) begin
          mv_nxt    = 2'd2;
          state_nxt = S_MV_LOC;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mv_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mv_r        <= mv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) op_r <= in_op;
  end

`ifndef ASSERT_OFF
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result valid rose outside finish");

  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DEC))
    else $error("accepted transfer not decoded");

  a_swap_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SW_A) |=> (state_r == S_SW_B) ##1 (state_r == S_SW_C)
      ##1 (state_r == S_SW_D))
    else $error("swap sequence broken");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.out_load)
    else $error("stalled result overwritten");
`endif

endmodule

### rtl/core/triplet_context_bucket_index_core.sv
// Triplet-context bucket index. Sites are loaded one bit per transfer (op 0);
// a build (op 1) counting-sorts inner sites into 8 context buckets over 8
// passes, each opening with a restart and then reading one load bit per
// cycle. A mutation (ops 2/3) flips a site and moves it and its inner
// neighbors between buckets with a chain of slot swaps; each swap reads the
// slot pair, reads the site pair, then writes both pairs back in turn on
// single-write-port memories. A ranked flip first looks its site up by rank.
// One transfer is worked at a time; a finished result sits in an output
// register so the next transfer is taken while it waits. Writing cfg_wdata
// (site count, clamped to 3..4096) clears the built index; write it only
// while idle.
module triplet_context_bucket_index_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [11:0] in_position,
  input  logic        in_bit_value,
  input  logic [2:0]  in_context_code,
  input  logic [11:0] in_rank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [11:0] out_mutated_position,
  output logic [11:0] out_count,
  output logic        out_site_bit
);

  tcbi_pkg::cmd_t cmd;
  tcbi_pkg::sts_t sts;

  // sequencer: decode, build passes, swap chains
  tcbi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // maps, bucket ends, result registers
  tcbi_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_position          (in_position),
    .in_bit_value         (in_bit_value),
    .in_context_code      (in_context_code),
    .in_rank              (in_rank),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_status           (out_status),
    .out_mutated_position (out_mutated_position),
    .out_count            (out_count),
    .out_site_bit         (out_site_bit)
  );

endmodule

### tb/tb_triplet_context_bucket_index_core.sv
`timescale 1ns / 1ps

module tb_triplet_context_bucket_index_core;

  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] mpos;
    logic [11:0] cnt;
    logic        sbit;
  } site_res_t;

  // Bucket index shadow: mirrors the site buckets and predicts each result.
  class bucket_index_sb;
    int unsigned n;
    bit          is_built;
    int unsigned slot_site[tcbi_pkg::MAX_SITES];
    int unsigned site_slot[tcbi_pkg::MAX_SITES];
    int unsigned b_end[tcbi_pkg::NUM_CTX];
    bit          bits[tcbi_pkg::MAX_SITES];
    bit          edge_lo, edge_hi;
    site_res_t   pending[$];
    int          errors;

    function new();
      n = tcbi_pkg::MAX_SITES;
      is_built = 0;
      errors = 0;
      edge_lo = 0;
      edge_hi = 0;
      foreach (slot_site[i]) begin
        slot_site[i] = 0;
        site_slot[i] = 0;
        bits[i] = 0;
      end
      foreach (b_end[i]) b_end[i] = 0;
    endfunction

    function void set_sites(logic [12:0] v);
      if (v < 13'd3) n = 3;
      else if (v > 13'(tcbi_pkg::MAX_SITES)) n = tcbi_pkg::MAX_SITES;
      else n = 32'(v);
      is_built = 0;
    endfunction

    function int unsigned lim(int unsigned x);
      return (x < tcbi_pkg::MAX_SITES) ? x : 0;
    endfunction

    function int unsigned b_first(int unsigned c);
      return (c == 0) ? 1 : b_end[(c - 1) & 7] + 1;
    endfunction

    function int unsigned bucket_size(int unsigned c);
      return b_end[c] + 1 - b_first(c);
    endfunction

    function void swap_pair(int unsigned a, int unsigned b);
      int unsigned sa, sb, t;
      a = lim(a);
      b = lim(b);
      sa = lim(slot_site[a]);
      sb = lim(slot_site[b]);
      slot_site[a] = sb;
      slot_site[b] = sa;
      t = site_slot[sa];
      site_slot[sa] = site_slot[sb];
      site_slot[sb] = t;
    endfunction

    function int unsigned ctx_at(int unsigned site);
      int unsigned idx, c;
      idx = site_slot[lim(site)];
      c = 0;
      while (c < 7 && b_end[c] < idx) c++;
      return c;
    endfunction

    function void relocate(int unsigned site, int unsigned from, int unsigned to);
      int unsigned loc, cur;
      loc = site_slot[lim(site)];
      cur = from & 7;
      to &= 7;
      if (to < cur) begin
        swap_pair(b_first(cur), loc);
        while (cur > to) begin
          swap_pair(b_end[cur - 1] + 1, b_first(cur - 1));
          b_end[cur - 1]++;
          cur--;
        end
      end else begin
        swap_pair(b_end[cur], loc);
        while (cur < to) begin
          swap_pair(b_end[cur], b_end[cur + 1]);
          b_end[cur]--;
          cur++;
        end
      end
    endfunction

    function void flip(int unsigned site);
      int unsigned c, cl, cr;
      c = ctx_at(site);
      cl = ctx_at(site - 1);
      cr = ctx_at(site + 1);
      relocate(site, c, c ^ 2);
      if (site - 1 > 0) relocate(site - 1, cl, cl ^ 1);
      if (site + 1 < n - 1) relocate(site + 1, cr, cr ^ 4);
    endfunction

    function void sort_sites();
      int unsigned slot, pat;
      slot = 1;
      for (int unsigned c = 0; c < tcbi_pkg::NUM_CTX; c++) begin
        for (int unsigned i = 1; i + 1 < n; i++) begin
          pat = bits[i - 1] * 4 + bits[i] * 2 + bits[i + 1];
          if (pat == c) begin
            slot_site[slot] = i;
            site_slot[i] = slot;
            slot++;
          end
        end
        b_end[c] = slot - 1;
      end
      edge_lo = bits[0];
      edge_hi = bits[n - 1];
      is_built = 1;
    endfunction

    // accepted input transfer: update the shadow and queue the expected result
    function void note_input(logic [2:0] op, logic [11:0] pos, logic bv,
                             logic [2:0] ctx, logic [11:0] rank);
      site_res_t r;
      int unsigned first, freq, site;
      r = '0;
      if (op inside {tcbi_pkg::OP_MUT_POS, tcbi_pkg::OP_MUT_RANK, tcbi_pkg::OP_COUNT,
                     tcbi_pkg::OP_READ} && !is_built) begin
        r.status = tcbi_pkg::ST_NOT_BUILT;
      end else begin
        case (op)
          tcbi_pkg::OP_LOAD: begin
            if (pos >= n) r.status = tcbi_pkg::ST_BAD_POS;
            else bits[pos] = bv;
          end
          tcbi_pkg::OP_BUILD: sort_sites();
          tcbi_pkg::OP_MUT_POS: begin
            if (pos < 1 || pos > n - 2) r.status = tcbi_pkg::ST_BAD_POS;
            else begin
              flip(pos);
              r.mpos = pos;
            end
          end
          tcbi_pkg::OP_MUT_RANK: begin
            first = b_first(ctx);
            freq = b_end[ctx] + 1 - first;
            if (freq == 0 || rank == 0 || rank > freq) r.status = tcbi_pkg::ST_BAD_CTX;
            else begin
              site = lim(slot_site[lim(first - 1 + rank)]);
              flip(site);
              r.mpos = 12'(site);
            end
          end
          tcbi_pkg::OP_COUNT: r.cnt = 12'(bucket_size(ctx));
          tcbi_pkg::OP_READ: begin
            if (pos >= n) r.status = tcbi_pkg::ST_BAD_POS;
            else if (pos == 0) r.sbit = edge_lo;
            else if (pos == n - 1) r.sbit = edge_hi;
            else r.sbit = 1'((ctx_at(pos) >> 1) & 1);
          end
          default: ;
        endcase
      end
      pending = {pending, r};
    endfunction

    function void check_result(site_res_t got);
      site_res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.mpos !== exp_r.mpos) begin
        $display("%0t: mutated_position exp %0d got %0d", $time, exp_r.mpos, got.mpos);
        errors++;
      end
      if (got.cnt !== exp_r.cnt) begin
        $display("%0t: count exp %0d got %0d", $time, exp_r.cnt, got.cnt);
        errors++;
      end
      if (got.sbit !== exp_r.sbit) begin
        $display("%0t: site_bit exp %0d got %0d", $time, exp_r.sbit, got.sbit);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [12:0] cfg_wdata = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [11:0] in_position = '0;
  logic        in_bit_value = 0;
  logic [2:0]  in_context_code = '0;
  logic [11:0] in_rank = '0;
  logic        out_valid;
  logic        out_stall = 1;
  logic [1:0]  out_status;
  logic [11:0] out_mutated_position;
  logic [11:0] out_count;
  logic        out_site_bit;

  bucket_index_sb sb = new();

  bit quiet = 0;      // phase without idle cycles on either side
  bit hold_req = 0;   // ask the receiver for one long hold-off
  int cycles = 0;

  triplet_context_bucket_index_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_position          (in_position),
    .in_bit_value         (in_bit_value),
    .in_context_code      (in_context_code),
    .in_rank              (in_rank),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_mutated_position (out_mutated_position),
    .out_count            (out_count),
    .out_site_bit         (out_site_bit)
  );

  always #4 clk = ~clk;

  // Watchdog: budget covers every transfer at its longest flip or build,
  // waiting out the worst gaps on both sides, with a wide margin.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls per transfer, plus one long hold-off on request
  // so the block backs up and stalls its input.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result({out_status, out_mutated_position, out_count, out_site_bit});
        stall_left = quiet ? 0 : int'($urandom_range(0, 10));
      end
      if (hold_req) begin
        hold_req = 0;
        stall_left = 400;
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // One input transfer. Valid stays high between back-to-back items.
  task automatic send(logic [2:0] op, logic [11:0] pos, logic bv,
                      logic [2:0] ctx, logic [11:0] rank);
    int gap;
    gap = quiet ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_position <= pos;
    in_bit_value <= bv;
    in_context_code <= ctx;
    in_rank <= rank;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, pos, bv, ctx, rank);
  endtask

  // Wait until every queued result has come out.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Register writes only with the block idle: drain, then let it settle.
  task automatic write_sites(logic [12:0] v);
    in_valid <= 0;
    drain();
    repeat (60) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_sites(v);
  endtask

  // Load every site of the current length with random bits, then build.
  task automatic fill_and_build();
    for (int unsigned i = 0; i < sb.n; i++)
      send(tcbi_pkg::OP_LOAD, 12'(i), 1'($urandom_range(0, 1)), 3'($urandom),
           12'($urandom));
    send(tcbi_pkg::OP_BUILD, 12'($urandom), 1'($urandom), 3'($urandom), 12'($urandom));
  endtask

  // Mostly well-formed mutations and queries with random content; some noise.
  task automatic random_ops(int count);
    int sel;
    logic [2:0] ctx;
    logic [11:0] rank, pos;
    for (int k = 0; k < count; k++) begin
      sel = int'($urandom_range(0, 99));
      ctx = 3'($urandom);
      pos = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, sb.n - 1));
      if (sel < 30) begin
        send(tcbi_pkg::OP_MUT_POS, pos, 1'($urandom), 3'($urandom), 12'($urandom));
      end else if (sel < 60) begin
        if (sb.bucket_size(ctx) > 0 && $urandom_range(0, 7) != 0)
          rank = 12'($urandom_range(1, sb.bucket_size(ctx)));
        else
          rank = ($urandom_range(0, 1) == 0) ? 12'd0 : 12'($urandom);
        send(tcbi_pkg::OP_MUT_RANK, 12'($urandom), 1'($urandom), ctx, rank);
      end else if (sel < 72) begin
        send(tcbi_pkg::OP_COUNT, 12'($urandom), 1'($urandom), ctx, 12'($urandom));
      end else if (sel < 88) begin
        send(tcbi_pkg::OP_READ, pos, 1'($urandom), 3'($urandom), 12'($urandom));
      end else if (sel < 95) begin
        // load after build only touches the load store until the next build
        send(tcbi_pkg::OP_LOAD, pos, 1'($urandom), 3'($urandom), 12'($urandom));
      end else if (sel < 97) begin
        send(tcbi_pkg::OP_BUILD, 12'($urandom), 1'($urandom), 3'($urandom), 12'($urandom));
      end else begin
        send(3'($urandom_range(6, 7)), 12'($urandom), 1'($urandom), 3'($urandom),
             12'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: nothing built yet, unknown ops, then a minimal 3-site sequence.
    send(tcbi_pkg::OP_MUT_POS, 12'd1, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_MUT_RANK, 12'd0, 1'b0, 3'd7, 12'd1);
    send(tcbi_pkg::OP_COUNT, 12'd0, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_READ, 12'd0, 1'b0, 3'd0, 12'd0);
    send(3'd6, 12'hfff, 1'b1, 3'd7, 12'hfff);
    send(3'd7, 12'd0, 1'b0, 3'd0, 12'd0);
    write_sites(13'd0);                       // clamps to 3 sites
    send(tcbi_pkg::OP_LOAD, 12'd0, 1'b1, 3'd0, 12'd0);
    send(tcbi_pkg::OP_LOAD, 12'd1, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_LOAD, 12'd2, 1'b1, 3'd0, 12'd0);
    send(tcbi_pkg::OP_LOAD, 12'd3, 1'b1, 3'd0, 12'd0);  // past the end
    send(tcbi_pkg::OP_LOAD, 12'hfff, 1'b1, 3'd0, 12'd0);
    send(tcbi_pkg::OP_BUILD, 12'd0, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_COUNT, 12'd0, 1'b0, 3'd5, 12'd0);
    send(tcbi_pkg::OP_COUNT, 12'd0, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_READ, 12'd0, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_READ, 12'd2, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_READ, 12'd3, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_MUT_POS, 12'd0, 1'b0, 3'd0, 12'd0); // edge site refused
    send(tcbi_pkg::OP_MUT_POS, 12'd2, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_MUT_POS, 12'd1, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_READ, 12'd1, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_MUT_RANK, 12'd0, 1'b0, 3'd7, 12'd1);   // now the only member
    send(tcbi_pkg::OP_MUT_RANK, 12'd0, 1'b0, 3'd5, 12'd0);   // rank zero
    send(tcbi_pkg::OP_MUT_RANK, 12'd0, 1'b0, 3'd5, 12'hfff); // rank too high
    send(tcbi_pkg::OP_MUT_RANK, 12'd0, 1'b0, 3'd0, 12'd1);   // empty context

    // Full length: loads anywhere in the 12-bit range, index cleared by the write.
    write_sites(13'h1fff);                    // clamps to 4096 sites
    send(tcbi_pkg::OP_COUNT, 12'($urandom), 1'($urandom), 3'($urandom), 12'($urandom));
    for (int k = 0; k < 24; k++)
      send(tcbi_pkg::OP_LOAD, 12'($urandom), 1'($urandom), 3'($urandom), 12'($urandom));
    send(tcbi_pkg::OP_LOAD, 12'hfff, 1'b1, 3'd0, 12'd0);
    send(tcbi_pkg::OP_READ, 12'hfff, 1'b0, 3'd0, 12'd0);
    send(tcbi_pkg::OP_MUT_RANK, 12'd0, 1'b0, 3'd2, 12'd1);

    // Short sequences, varied lengths; one phase with a long result hold-off.
    for (int ph = 0; ph < 9; ph++) begin
      write_sites((ph == 0) ? 13'd4 : 13'($urandom_range(5, 64)));
      quiet = ($urandom_range(0, 3) == 0);
      send(tcbi_pkg::OP_READ, 12'($urandom), 1'($urandom), 3'($urandom), 12'($urandom));
      fill_and_build();
      if (ph == 3) hold_req = 1;
      random_ops(110);
      quiet = 0;
    end

    in_valid <= 0;
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/tcbi_pkg.sv
rtl/core/tcbi_dp.sv
rtl/core/tcbi_ctrl.sv
rtl/core/triplet_context_bucket_index_core.sv
tb/tb_triplet_context_bucket_index_core.sv
